// ===== src/ssmd_pkg.sv =====
// Shared types, constants and the segment decode table for the seven-segment driver.
package ssmd_pkg;

    // Default number of display digits.
    localparam int MAX_DIGITS_DEF = 8;

    // Binary input width and the decimal digits it can produce.
    localparam int BIN_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    // Command queue depth between front and back.
    localparam int Q_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIGITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_LEVEL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_EN = 2'd3;

    localparam logic [3:0] NUM_DIGITS_RESET = 4'd8;
    localparam logic [3:0] POINT_NONE       = 4'hF;

    // Input op codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [31:0]       number;
        logic signed [3:0] point_index;
    } in_item_t;

    typedef struct packed {
        logic [6:0] segment_levels;
        logic       point_level;
        logic [7:0] digit_enable_levels;
        logic [2:0] active_digit;
    } out_item_t;

    typedef struct packed {
        logic [3:0] num_digits;
        logic       seg_level;
        logic       en_level;
        logic       enabled;
    } cfg_t;

    // Work classified by the front end.
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SCAN,
        CMD_HOLD
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] number;
        logic [3:0]  point;
    } q_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_COMMIT
    } back_state_t;

    // Digit value to segments a..g (bit 0 is a); non-decimal codes go dark.
    function automatic logic [6:0] seg_decode(input logic [3:0] val);
        logic [6:0] pat;
        case (val)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/ssmd_front.sv =====
// Front end: accepts input items, classifies them and queues commands for the back end.
module ssmd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ssmd_pkg::in_item_t  in_data,
    input  logic                display_enabled,
    output logic                q_valid,
    output ssmd_pkg::q_entry_t  q_entry,
    input  logic                q_pop
);
    import ssmd_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    q_entry_t           mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    q_entry_t           new_entry;

    // Classify: ticks while blanked only report current levels
    always_comb
    begin
        new_entry.number = in_data.number;
        new_entry.point  = in_data.point_index;
        if (in_data.op == OP_WRITE)
            new_entry.cmd = CMD_WRITE;
        else if (display_enabled)
            new_entry.cmd = CMD_SCAN;
        else
            new_entry.cmd = CMD_HOLD;
    end

    assign in_stall = (count_reg == CNT_W'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= new_entry;
    end

endmodule

// ===== src/ssmd_bcd.sv =====
// Shift-and-add-3 binary to decimal converter, one input bit per cycle.
module ssmd_bcd (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ssmd_pkg::BIN_W-1:0]  number,
    output logic                        busy,
    output logic [ssmd_pkg::BCD_W-1:0]  digits
);
    import ssmd_pkg::*;

    localparam int CNT_W = $clog2(BIN_W + 1);

    logic [BIN_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] adj;
    logic [CNT_W-1:0] cnt_reg;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_W'(BIN_W);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= number;
            bcd_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            {bcd_reg, bin_reg} <= {adj[BCD_W-2:0], bin_reg, 1'b0};
        end
    end

    assign busy   = (cnt_reg != '0);
    assign digits = bcd_reg;

endmodule

// ===== src/ssmd_back.sv =====
// Back end: runs queued commands, holds digit store and pin states, drives the result register.
module ssmd_back #(
    parameter int MAX_DIGITS = ssmd_pkg::MAX_DIGITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssmd_pkg::cfg_t       cfg,
    input  logic                 clr_en,
    input  logic                 q_valid,
    input  ssmd_pkg::q_entry_t   q_entry,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ssmd_pkg::out_item_t  out_data,
    output logic                 busy,
    output logic [MAX_DIGITS-1:0] enable_pins
);
    import ssmd_pkg::*;

    localparam int SCAN_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CMP_W  = SCAN_W + 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int PT_W   = (SCAN_W > 3) ? SCAN_W : 3;

    back_state_t            state_reg, state_next;
    logic [SCAN_W-1:0]      scan_reg;
    logic [3:0]             point_reg;
    logic [3:0]             pend_point_reg;
    logic [7:0]             seg_pins_reg;
    logic [MAX_DIGITS-1:0]  en_pins_reg;
    logic [3:0]             store_reg [MAX_DIGITS];
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;

    logic                   out_free;
    logic                   bcd_start;
    logic                   bcd_busy;
    logic [BCD_W-1:0]       bcd_digits;
    logic [3:0]             conv_digit [MAX_DIGITS];
    logic                   do_scan;
    logic                   load_out;
    logic                   commit;

    logic [CNT_W-1:0]       used;
    logic [CMP_W-1:0]       inc_idx;
    logic [SCAN_W-1:0]      next_idx;
    logic                   pt_on;
    logic [7:0]             seg_next;
    logic [MAX_DIGITS-1:0]  en_next;
    logic [7:0]             seg_emit;
    logic [MAX_DIGITS-1:0]  en_emit;
    logic [SCAN_W-1:0]      scan_emit;
    logic [7:0]             en_on;

    ssmd_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .number (q_entry.number),
        .busy   (bcd_busy),
        .digits (bcd_digits)
    );

    // Digits in use, clamped to 1..MAX_DIGITS
    always_comb
    begin
        if (cfg.num_digits == '0)
            used = CNT_W'(1);
        else if ({1'b0, cfg.num_digits} > 5'(MAX_DIGITS))
            used = CNT_W'(MAX_DIGITS);
        else
            used = CNT_W'(cfg.num_digits);
    end

    // Converter digits mapped onto store entries; entries past ten stay zero
    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_conv
        if (i < BCD_DIGITS)
        begin : g_dig
            assign conv_digit[i] = bcd_digits[4*i +: 4];
        end
        else
        begin : g_zero
            assign conv_digit[i] = 4'd0;
        end
    end

    // Next scan position and its pin pattern
    always_comb
    begin
        inc_idx  = CMP_W'(scan_reg) + 1'b1;
        next_idx = (inc_idx >= CMP_W'(used)) ? '0 : inc_idx[SCAN_W-1:0];
        pt_on    = !point_reg[3] && (PT_W'(point_reg[2:0]) == PT_W'(next_idx));
        seg_next = {pt_on, seg_decode(store_reg[next_idx])};
        en_next  = MAX_DIGITS'(1) << next_idx;
    end

    // Command sequencing
    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        state_next = state_reg;
        q_pop      = 1'b0;
        bcd_start  = 1'b0;
        do_scan    = 1'b0;
        load_out   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_entry.cmd == CMD_WRITE)
                    begin
                        q_pop      = 1'b1;
                        bcd_start  = 1'b1;
                        state_next = BK_CONV;
                    end
                    else if (out_free)
                    begin
                        q_pop    = 1'b1;
                        load_out = 1'b1;
                        do_scan  = (q_entry.cmd == CMD_SCAN);
                    end
                end
            end
            BK_CONV:
            begin
                if (!bcd_busy)
                    state_next = BK_COMMIT;
            end
            BK_COMMIT:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Result levels after polarity
    assign seg_emit  = do_scan ? seg_next : seg_pins_reg;
    assign en_emit   = do_scan ? en_next  : en_pins_reg;
    assign scan_emit = do_scan ? next_idx : scan_reg;

    for (genvar d = 0; d < 8; d++)
    begin : g_en
        if (d < MAX_DIGITS)
        begin : g_live
            assign en_on[d] = en_emit[d] && (int'(used) > d);
        end
        else
        begin : g_dead
            assign en_on[d] = 1'b0;
        end
    end

    always_comb
    begin
        out_data_next.segment_levels      = cfg.seg_level ? seg_emit[6:0] : ~seg_emit[6:0];
        out_data_next.point_level         = seg_emit[7] ^ ~cfg.seg_level;
        out_data_next.digit_enable_levels = cfg.en_level ? en_on : ~en_on;
        out_data_next.active_digit        = 3'(scan_emit);

        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and pin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            scan_reg      <= '0;
            point_reg     <= POINT_NONE;
            seg_pins_reg  <= '0;
            en_pins_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_scan)
            begin
                scan_reg     <= next_idx;
                seg_pins_reg <= seg_next;
            end
            if (clr_en)
                en_pins_reg <= '0;
            else if (do_scan)
                en_pins_reg <= en_next;
            if (commit)
            begin
                point_reg <= pend_point_reg;
                for (int i = 0; i < MAX_DIGITS; i++)
                    store_reg[i] <= (i < int'(used)) ? conv_digit[i] : 4'd0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (bcd_start)
            pend_point_reg <= q_entry.point;
        if (load_out)
            out_data_reg <= out_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign busy        = (state_reg != BK_IDLE);
    assign enable_pins = en_pins_reg;

endmodule

// ===== src/seven_segment_mux_driver_core.sv =====
// Top level of the multiplexed seven-segment display driver.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | input     | in_valid/in_stall  | op, number, point_index
//  out     | output    | out_valid/out_stall| segment_levels, point_level,
//          |           |                    | digit_enable_levels, active_digit
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A scan tick or blanked tick goes through the command queue and then the result register.
// A number write goes through the command queue, a pop, the converter (one bit of the
// number per cycle), a done check, store commit and the result register, in that
// order.
// A two-entry command queue lets inputs transfer while the back end works.
// Reset clears the digit store, scan position and pins and restores configuration defaults.
// A stalled result is held in the output register; the queue fills behind it.
module seven_segment_mux_driver_core #(
    parameter int MAX_DIGITS = ssmd_pkg::MAX_DIGITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ssmd_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ssmd_pkg::out_item_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ssmd_pkg::*;

    cfg_t                   cfg_reg;
    logic                   cfg_wr;
    logic                   clr_en;
    logic                   q_valid;
    q_entry_t               q_entry;
    logic                   q_pop;
    logic                   bk_busy;
    logic [MAX_DIGITS-1:0]  enable_pins;

    // Configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign clr_en    = cfg_wr && (cfg_index == CFG_DISPLAY_EN) && !cfg_data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_digits <= NUM_DIGITS_RESET;
            cfg_reg.seg_level  <= 1'b1;
            cfg_reg.en_level   <= 1'b1;
            cfg_reg.enabled    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_NUM_DIGITS: cfg_reg.num_digits <= cfg_data[3:0];
                CFG_SEG_LEVEL:  cfg_reg.seg_level  <= cfg_data[0];
                CFG_EN_LEVEL:   cfg_reg.en_level   <= cfg_data[0];
                CFG_DISPLAY_EN: cfg_reg.enabled    <= cfg_data[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    ssmd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .display_enabled (cfg_reg.enabled),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop)
    );

    ssmd_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clr_en      (clr_en),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .busy        (bk_busy),
        .enable_pins (enable_pins)
    );

    // The back end never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");

    // A write command always starts a conversion
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_entry.cmd == CMD_WRITE)) |=> bk_busy)
        else $error("write transfer did not start conversion");

    // At most one digit is enabled at a time
    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(enable_pins))
        else $error("more than one digit enable active");

endmodule
